FILE: src/dpfc_pkg.sv
// Shared types, constants and helpers for the debug packet frame checker.
`default_nettype none
package dpfc_pkg;

	// Framing characters and minimum frame length ('$' .. '#' plus two digits)
	localparam logic [7:0] START_MARK = 8'h24;
	localparam logic [7:0] END_MARK   = 8'h23;
	localparam logic [2:0] MIN_FRAME  = 3'd4;
	localparam logic [7:0] ESC_RESET  = 8'd125;

	// Frame parser phase
	typedef enum logic [1:0] {
		PH_HUNT    = 2'd0,
		PH_PAYLOAD = 2'd1,
		PH_AFTER   = 2'd2
	} phase_t;

	// Verdict codes
	typedef enum logic [2:0] {
		ST_GOOD     = 3'd0,
		ST_NO_START = 3'd1,
		ST_SHORT    = 3'd2,
		ST_NO_END   = 3'd3,
		ST_DIGITS   = 3'd4,
		ST_BAD_HEX  = 3'd5,
		ST_MISMATCH = 3'd6
	} status_t;

	// Per-frame parser state
	typedef struct packed {
		phase_t      phase;
		logic        esc_pend;
		logic [7:0]  sum;
		logic [2:0]  pkt_len;
		logic [1:0]  digits;
		logic [3:0]  hi_nib;
		logic        hex_err;
	} frame_state_t;

	// One result item
	typedef struct packed {
		logic [7:0] payload_byte;
		logic       payload_valid;
		logic       verdict_valid;
		status_t    status;
	} result_t;

	localparam frame_state_t FRAME_CLEAR = '{
		phase:    PH_HUNT,
		esc_pend: 1'b0,
		sum:      8'd0,
		pkt_len:  3'd0,
		digits:   2'd0,
		hi_nib:   4'd0,
		hex_err:  1'b0
	};

	// Hex digit value; bit 4 set means not a hex digit
	function automatic logic [4:0] hex_value(input logic [7:0] b);
		logic [4:0] v;
		begin
			if (b >= 8'h30 && b <= 8'h39) begin
				v = {1'b0, 4'(b - 8'h30)};
			end else if (b >= 8'h61 && b <= 8'h66) begin
				v = {1'b0, 4'(b - 8'h57)};
			end else if (b >= 8'h41 && b <= 8'h46) begin
				v = {1'b0, 4'(b - 8'h37)};
			end else begin
				v = 5'h10;
			end
			return v;
		end
	endfunction

endpackage
`default_nettype wire

FILE: src/dpfc_step.sv
// Next-state and result logic for one byte of the frame checker.
`default_nettype none
module dpfc_step (
	input  dpfc_pkg::frame_state_t st,
	input  logic [7:0]             esc_char,
	input  logic [7:0]             data_byte,
	input  logic                   last,
	output dpfc_pkg::frame_state_t nxt,
	output dpfc_pkg::result_t      res
);
	import dpfc_pkg::*;

	logic [4:0] hv;
	logic       pay_v;
	logic [7:0] rx;
	status_t    status;

	always_comb begin
		hv     = hex_value(data_byte);
		nxt    = st;
		pay_v  = 1'b0;
		status = ST_GOOD;
		rx     = {st.hi_nib, hv[3:0]};

		// Byte processing by phase
		case (st.phase)
			PH_PAYLOAD: begin
				if (st.pkt_len < MIN_FRAME) nxt.pkt_len = st.pkt_len + 3'd1;
				if (st.esc_pend) begin
					nxt.esc_pend = 1'b0;
					pay_v        = 1'b1;
				end else if (data_byte == esc_char) begin
					nxt.esc_pend = 1'b1;
					pay_v        = 1'b1;
				end else if (data_byte == END_MARK) begin
					nxt.phase  = PH_AFTER;
					nxt.digits = 2'd0;
				end else begin
					pay_v = 1'b1;
				end
				if (pay_v) nxt.sum = st.sum + data_byte;
			end
			PH_AFTER: begin
				if (st.pkt_len < MIN_FRAME) nxt.pkt_len = st.pkt_len + 3'd1;
				if (st.digits < 2'd2) begin
					if (hv[4]) begin
						nxt.hex_err = 1'b1;
					end else if (st.digits == 2'd0) begin
						nxt.hi_nib = hv[3:0];
					end
				end
				if (st.digits < 2'd3) nxt.digits = st.digits + 2'd1;
			end
			default: begin
				// hunting; the unused phase code behaves the same
				if (st.esc_pend) begin
					nxt.esc_pend = 1'b0;
				end else if (data_byte == esc_char) begin
					nxt.esc_pend = 1'b1;
				end else if (data_byte == START_MARK) begin
					nxt         = FRAME_CLEAR;
					nxt.phase   = PH_PAYLOAD;
					nxt.pkt_len = 3'd1;
				end
			end
		endcase

		// Verdict on the buffer's last byte, then back to hunting
		if (last) begin
			if (nxt.phase != PH_PAYLOAD && nxt.phase != PH_AFTER) begin
				status = ST_NO_START;
			end else if (nxt.pkt_len < MIN_FRAME) begin
				status = ST_SHORT;
			end else if (nxt.phase == PH_PAYLOAD) begin
				status = ST_NO_END;
			end else if (nxt.digits != 2'd2) begin
				status = ST_DIGITS;
			end else if (nxt.hex_err) begin
				status = ST_BAD_HEX;
			end else if (rx != nxt.sum) begin
				status = ST_MISMATCH;
			end
			nxt = FRAME_CLEAR;
		end

		res.payload_byte  = pay_v ? data_byte : 8'd0;
		res.payload_valid = pay_v;
		res.verdict_valid = last;
		res.status        = status;
	end

endmodule
`default_nettype wire

FILE: src/debug_packet_frame_checker.sv
// Top level: input register, frame parser state, result register and handshakes.
// Each accepted byte passes from the input register through the single-pass
// parser state update into the result register. One byte per cycle unless the
// output stalls; the input register can hold a new byte while a result waits.
// Reset (arst_n low, asynchronous): parser hunts for '$', sums and counts clear,
// escape character returns to 125, both pipeline registers empty.
`default_nettype none
module debug_packet_frame_checker (
	input  logic        clk,
	input  logic        arst_n,
	// configuration: escape character
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	// input stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] data_byte
	input  logic        s_tlast,   // end_of_buffer
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] payload_byte, [10:8] status, rest zero
	output logic        m_tuser,   // payload_valid
	output logic        m_tlast    // verdict_valid
);
	import dpfc_pkg::*;

	logic         vld_s1;
	logic [7:0]   data_s1;
	logic         last_s1;
	logic         vld_s2;
	result_t      res_s2;
	frame_state_t state_q;
	logic [7:0]   esc_q;
	frame_state_t state_nxt;
	result_t      res_nxt;
	logic         adv;

	// Stage 1 moves on when the result register is empty or draining
	assign adv       = vld_s1 && (!vld_s2 || m_tready);
	assign s_tready  = !vld_s1 || adv;
	assign cfg_ready = 1'b1;

	// Escape character register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= ESC_RESET;
		end else if (cfg_valid && cfg_ready) begin
			esc_q <= cfg_data;
		end
	end

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (s_tready) begin
			vld_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			last_s1 <= s_tlast;
		end
	end

	dpfc_step u_step (
		.st        (state_q),
		.esc_char  (esc_q),
		.data_byte (data_s1),
		.last      (last_s1),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	// Parser state and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FRAME_CLEAR;
			vld_s2  <= 1'b0;
		end else begin
			if (adv) state_q <= state_nxt;
			if (adv) begin
				vld_s2 <= 1'b1;
			end else if (m_tready) begin
				vld_s2 <= 1'b0;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (adv) res_s2 <= res_nxt;
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {5'd0, res_s2.status, res_s2.payload_byte};
	assign m_tuser  = res_s2.payload_valid;
	assign m_tlast  = res_s2.verdict_valid;

	// A drained result always frees room for a new request
	a_drain_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready |-> s_tready)
		else $error("input stalled while result drains");

	// Buffer end returns the parser to a clean hunt
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		adv && last_s1 |=> state_q.phase == PH_HUNT && state_q.sum == 8'd0 &&
			state_q.pkt_len == 3'd0 && !state_q.esc_pend)
		else $error("frame state not cleared after buffer end");

	// Status only carries a code with a verdict
	a_status_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tlast |-> m_tdata[10:8] == 3'd0)
		else $error("status without verdict");

	// Payload byte is zero when not payload
	a_payload_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tdata[7:0] == 8'd0)
		else $error("payload byte without payload flag");

	// Parser state only moves when a request advances
	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(state_q))
		else $error("parser state changed without a request");

endmodule
`default_nettype wire

FILE: test/debug_packet_frame_checker_test.sv
// Self-checking testbench for the frame checker: framed buffers in, checked results out.
`timescale 1ns / 1ps
module debug_packet_frame_checker_test;
	import dpfc_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 4;
	localparam int HOLD_CYCLES  = 64;
	localparam int PRINT_CAP    = 20;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'd0;    // [7:0] data_byte
	logic        s_tlast = 1'b0;    // end_of_buffer
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;           // [7:0] payload_byte, [10:8] status
	logic        m_tuser;           // payload_valid
	logic        m_tlast;           // verdict_valid

	// parser model state
	logic [7:0]   esc_model = ESC_RESET;
	frame_state_t parse_state = FRAME_CLEAR;
	result_t      byte_results[$];

	// traffic shaping
	int src_idle_pct = 0;
	int sink_stall_pct = 0;
	int hold_cycles = 0;

	// bookkeeping
	int fail_count = 0;
	int bytes_sent = 0;
	int buffers_sent = 0;
	int results_seen = 0;
	int esc_settings = 1;
	int quiet = 0;
	int verdict_seen[7];

	debug_packet_frame_checker u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #2 clk = ~clk;

	// hex digit value, bit 4 flags a non-hex byte
	function automatic logic [4:0] digit_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return {1'b0, c[3:0]};
		if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
			return {1'b0, c[3:0] + 4'd9};
		return 5'h10;
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] v, input logic upper);
		if (v < 4'd10) return 8'h30 + {4'h0, v};
		return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
	endfunction

	// Advance the parser model by one byte and return the result it owes
	function automatic result_t parse_byte(input logic [7:0] b, input logic last);
		result_t    r;
		logic [4:0] nib;
		logic [7:0] rx;
		r = '0;
		r.status = ST_GOOD;
		case (parse_state.phase)
			PH_PAYLOAD: begin
				if (parse_state.pkt_len < MIN_FRAME)
					parse_state.pkt_len = parse_state.pkt_len + 3'd1;
				if (parse_state.esc_pend) begin
					parse_state.esc_pend = 1'b0;
					r.payload_valid = 1'b1;
				end else if (b == esc_model) begin
					parse_state.esc_pend = 1'b1;
					r.payload_valid = 1'b1;
				end else if (b == END_MARK) begin
					parse_state.phase = PH_AFTER;
					parse_state.digits = 2'd0;
				end else begin
					r.payload_valid = 1'b1;
				end
				if (r.payload_valid) begin
					r.payload_byte = b;
					parse_state.sum = parse_state.sum + b;
				end
			end
			PH_AFTER: begin
				if (parse_state.pkt_len < MIN_FRAME)
					parse_state.pkt_len = parse_state.pkt_len + 3'd1;
				if (parse_state.digits < 2'd2) begin
					nib = digit_value(b);
					if (nib[4]) parse_state.hex_err = 1'b1;
					else if (parse_state.digits == 2'd0) parse_state.hi_nib = nib[3:0];
				end
				if (parse_state.digits < 2'd3) parse_state.digits = parse_state.digits + 2'd1;
			end
			default: begin
				// hunting, unused phase code included
				if (parse_state.esc_pend) begin
					parse_state.esc_pend = 1'b0;
				end else if (b == esc_model) begin
					parse_state.esc_pend = 1'b1;
				end else if (b == START_MARK) begin
					parse_state = FRAME_CLEAR;
					parse_state.phase = PH_PAYLOAD;
					parse_state.pkt_len = 3'd1;
				end
			end
		endcase

		// verdict on the buffer's last byte, in priority order
		if (last) begin
			r.verdict_valid = 1'b1;
			if (parse_state.phase != PH_PAYLOAD && parse_state.phase != PH_AFTER) begin
				r.status = ST_NO_START;
			end else if (parse_state.pkt_len < MIN_FRAME) begin
				r.status = ST_SHORT;
			end else if (parse_state.phase == PH_PAYLOAD) begin
				r.status = ST_NO_END;
			end else if (parse_state.digits != 2'd2) begin
				r.status = ST_DIGITS;
			end else if (parse_state.hex_err) begin
				r.status = ST_BAD_HEX;
			end else begin
				// this byte is the low checksum digit
				nib = digit_value(b);
				rx = {parse_state.hi_nib, nib[3:0]};
				r.status = (rx == parse_state.sum) ? ST_GOOD : ST_MISMATCH;
			end
			parse_state = FRAME_CLEAR;
		end
		return r;
	endfunction

	// Offer one byte, idling first as the current phase asks
	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		byte_results.push_back(parse_byte(b, last));
		bytes_sent++;
		if (last) buffers_sent++;
	endtask

	task automatic send_text(input string s, input logic ends);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], ends && (i == s.len() - 1));
	endtask

	// Stop offering and wait for every owed result
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (byte_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_escape(input logic [7:0] v);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		esc_model = v;
		esc_settings++;
	endtask

	// One random buffer: mostly well-formed frames, the rest broken in one way
	task automatic send_buffer();
		logic [7:0] bytes_q[$];
		logic [7:0] sum, b, d0, d1, bad;
		logic [4:0] v;
		int kind, n;
		kind = $urandom_range(99);
		sum = 8'd0;
		// noise ahead of the start marker
		n = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : 0;
		repeat (n) bytes_q.push_back(8'($urandom));
		if (kind >= 6) bytes_q.push_back(START_MARK);
		// payload, mostly short; escape pairs hide markers
		n = ($urandom_range(9) == 0) ? $urandom_range(12, 24) : $urandom_range(0, 6);
		repeat (n) begin
			if ($urandom_range(7) == 0) begin
				bytes_q.push_back(esc_model);
				case ($urandom_range(3))
					0: b = START_MARK;
					1: b = END_MARK;
					2: b = esc_model;
					default: b = 8'($urandom);
				endcase
				sum = sum + esc_model + b;
			end else begin
				do b = 8'($urandom); while (b == END_MARK || b == esc_model);
				sum = sum + b;
			end
			bytes_q.push_back(b);
		end
		if (kind >= 12) begin
			bytes_q.push_back(END_MARK);
			d0 = hex_char(sum[7:4], 1'($urandom));
			d1 = hex_char(sum[3:0], 1'($urandom));
			if (kind >= 30 && kind < 38)
				d1 = hex_char(sum[3:0] + 4'($urandom_range(1, 15)), 1'($urandom));
			if (kind >= 24 && kind < 30) begin
				bad = 8'($urandom);
				v = digit_value(bad);
				while (!v[4]) begin
					bad = 8'($urandom);
					v = digit_value(bad);
				end
				if ($urandom_range(1)) d0 = bad;
				else d1 = bad;
			end
			bytes_q.push_back(d0);
			if (kind >= 18 || kind < 12) bytes_q.push_back(d1);
			// too many digits
			if (kind >= 18 && kind < 24) begin
				repeat ($urandom_range(1, 3))
					bytes_q.push_back(hex_char(4'($urandom), 1'($urandom)));
			end
		end
		if (bytes_q.size() == 0) bytes_q.push_back(8'($urandom));
		foreach (bytes_q[i]) send_byte(bytes_q[i], i == bytes_q.size() - 1);
	endtask

	task automatic run_buffers(input int n);
		int stop;
		stop = bytes_sent + n;
		while (bytes_sent < stop) send_buffer();
	endtask

	// ---- test tasks ----

	task automatic test_directed();
		send_text("x", 1'b1);             // no start marker
		send_text("$#", 1'b1);            // too short
		send_text("$abc", 1'b1);          // payload with no end marker
		send_text("$a#6", 1'b1);          // one checksum digit
		send_text("$#g0", 1'b1);          // bad hex digit
		send_text("$#0a", 1'b1);          // checksum mismatch, lowercase digit
		// escaped start while hunting, escaped end in payload, extreme byte values
		send_byte(8'h00, 1'b0);
		send_text("}$$", 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text("}##9F", 1'b1);
	endtask

	task automatic test_escape_settings();
		write_escape(8'h00);
		run_buffers(25);
		write_escape(8'hFF);
		run_buffers(25);
		// escape equal to a marker hides that marker for good
		write_escape(START_MARK);
		run_buffers(25);
		write_escape(END_MARK);
		run_buffers(25);
		write_escape(8'($urandom));
		run_buffers(25);
		write_escape(ESC_RESET);
		run_buffers(25);
	endtask

	task automatic test_random_traffic();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		run_buffers(170);
		src_idle_pct = 61;
		run_buffers(170);
		src_idle_pct = 0;
		sink_stall_pct = 61;
		run_buffers(170);
		src_idle_pct = 30;
		sink_stall_pct = 30;
		run_buffers(170);
	endtask

	task automatic test_backpressure();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		// long receiver hold-off while requests keep coming
		hold_cycles <= HOLD_CYCLES;
		run_buffers(30);
		// sender pauses until every result is back
		wait_drained();
		run_buffers(10);
	endtask

	// ---- receiver ready ----
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			m_tready <= 1'b0;
			hold_cycles <= hold_cycles - 1;
		end else begin
			m_tready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	// ---- result checker ----
	always @(posedge clk) begin
		result_t want, got;
		if (m_tvalid && m_tready) begin
			got = '{payload_byte: m_tdata[7:0], payload_valid: m_tuser,
				verdict_valid: m_tlast, status: status_t'(m_tdata[10:8])};
			if (byte_results.size() == 0) begin
				fail_count++;
				if (fail_count <= PRINT_CAP)
					$display("%0t: unexpected result %h, nothing outstanding", $time, got);
			end else begin
				want = byte_results.pop_front();
				results_seen++;
				if (want.verdict_valid) verdict_seen[want.status]++;
				if (got !== want) begin
					fail_count++;
					if (fail_count <= PRINT_CAP)
						$display("%0t: expected %h/%b/%b/%0d actual %h/%b/%b/%0d",
							$time, want.payload_byte, want.payload_valid,
							want.verdict_valid, want.status, got.payload_byte,
							got.payload_valid, got.verdict_valid, got.status);
				end
			end
		end
	end

	// ---- watchdog: cycles without any handshake ----
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
			$display("debug_packet_frame_checker regression: fail");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	// ---- sequence ----
	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_escape_settings();
		test_random_traffic();
		test_backpressure();
		src_idle_pct = 0;
		sink_stall_pct = 0;
		wait_drained();
		if (byte_results.size() != 0) begin
			fail_count++;
			$display("%0t: %0d results never arrived", $time, byte_results.size());
		end
		$display("covered %0d bytes in %0d buffers, %0d results, %0d escape settings",
			bytes_sent, buffers_sent, results_seen, esc_settings);
		$display("verdicts: good %0d no-start %0d short %0d no-end %0d",
			verdict_seen[ST_GOOD], verdict_seen[ST_NO_START], verdict_seen[ST_SHORT],
			verdict_seen[ST_NO_END]);
		$display("verdicts: digits %0d hex %0d sum %0d",
			verdict_seen[ST_DIGITS], verdict_seen[ST_BAD_HEX], verdict_seen[ST_MISMATCH]);
		if (fail_count == 0) begin
			$display("debug_packet_frame_checker regression: pass");
		end else begin
			$display("debug_packet_frame_checker regression: fail");
		end
		$finish;
	end

endmodule
